// ===== hw/rtl/windowed_jerk_snap_estimator_assert.svh =====
// Assertion macros for the jerk and snap estimator
`ifndef WINDOWED_JERK_SNAP_ESTIMATOR_ASSERT_SVH
`define WINDOWED_JERK_SNAP_ESTIMATOR_ASSERT_SVH

// a |-> b, checked while out of reset
`define WJS_ASSERT_IMPL(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("implication failed");

// a |=> b, checked while out of reset
`define WJS_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/wjse_pkg.sv =====
// ----------------------------------------------------------------------------
// wjse_pkg
// Shared constants and types for the windowed jerk and snap estimator.
// ----------------------------------------------------------------------------
package wjse_pkg;
	localparam int WindowPoints = 8;
	localparam int JerkDepth = WindowPoints - 1;
	localparam int SnapDepth = WindowPoints - 2;
	localparam int JerkIdxW = (JerkDepth > 1) ? $clog2(JerkDepth) : 1;
	localparam int SnapIdxW = (SnapDepth > 1) ? $clog2(SnapDepth) : 1;
	localparam int TotalW = 32 + $clog2(JerkDepth + 1);
	localparam logic [29:0] TpsReset = 30'd1000000;

	// means by reciprocal multiply: q = (|total| * ceil(2^shift / depth)) >> shift
	localparam int MagW = TotalW - 1;
	localparam int RecipLoW = 18;
	localparam int RecipHiW = TotalW - RecipLoW;
	localparam int AvgProdW = MagW + TotalW;
	localparam int JerkShift = MagW + $clog2(JerkDepth);
	localparam int SnapShift = MagW + $clog2(SnapDepth);
	localparam logic [TotalW-1:0] JerkRecip =
		TotalW'(((64'd1 << JerkShift) + 64'(JerkDepth - 1)) / 64'(JerkDepth));
	localparam logic [TotalW-1:0] SnapRecip =
		TotalW'(((64'd1 << SnapShift) + 64'(SnapDepth - 1)) / 64'(SnapDepth));

	typedef struct packed {
		logic load;      // capture input item
		logic jerk_div;  // start jerk division
		logic snap_div;  // start snap division
		logic update;    // update rings and sums
		logic avg_start; // start averaging divisions
	} wjse_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic avg_busy;
	} wjse_sts_t;
endpackage

// ===== hw/rtl/windowed_jerk_snap_estimator.sv =====
// ----------------------------------------------------------------------------
// windowed_jerk_snap_estimator
// Jerk and snap from timestamped acceleration, averaged over short windows.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one sample item (time, accel). m_axis returns one
// result item per sample (jerk mean, snap mean, zero time step flag).
// ticks_per_second is written through cfg_we/cfg_wdata while idle.
// After a sample is accepted, m_axis_tvalid rises once it has gone through two passes
// of a shared 64-step serial divider (jerk rate, then snap rate), each
// with its registered multiply and handoff, then the ring update, the start
// of the means and the low and high reciprocal multiplies that divide both
// sums by the window depth.
// One item is in flight at a time; s_axis_tready is high only when idle,
// so a new item is taken only once the previous result has been accepted.
// Reset clears the rings, sums, previous sample and sets ticks_per_second
// to 1000000. A stalled receiver holds the result on m_axis and blocks
// the next sample until it is taken.
// ----------------------------------------------------------------------------
`include "windowed_jerk_snap_estimator_assert.svh"
module windowed_jerk_snap_estimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [29:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // sample_time[63:0], accel_sample[95:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // jerk_average[31:0], snap_average[63:32]
	output logic        m_axis_tuser   // zero_step_flag
);
	import wjse_pkg::*;

	logic [29:0] tps_q;
	wjse_cmd_t   cmd;
	wjse_sts_t   sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tps_q <= TpsReset;
		else if (cfg_we) tps_q <= cfg_wdata;
	end

	wjse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd(cmd), .sts(sts)
	);

	wjse_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .tps(tps_q), .in_time(s_axis_tdata[63:0]),
		.in_accel(s_axis_tdata[95:64]), .cmd(cmd), .sts(sts),
		.jerk_avg(m_axis_tdata[31:0]), .snap_avg(m_axis_tdata[63:32]),
		.zero_flag(m_axis_tuser)
	);

	`WJS_ASSERT_IMPL(a_no_accept_busy, s_axis_tready, !m_axis_tvalid)
	`WJS_ASSERT_NEXT(a_load_starts, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`WJS_ASSERT_IMPL(a_one_hot_cmd, 1'b1, $onehot0(cmd))
endmodule

// ===== hw/rtl/wjse_div.sv =====
// ----------------------------------------------------------------------------
// wjse_div
// Unsigned radix-2 restoring divider, 64 by 64 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module wjse_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic [63:0] quo
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] den_q;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign busy = (cnt_q != 7'd0);
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

// ===== hw/rtl/wjse_datapath.sv =====
// ----------------------------------------------------------------------------
// wjse_datapath
// Differences, scaled rate divisions, rings, running sums and means.
// ----------------------------------------------------------------------------
module wjse_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [29:0]       tps,
	input  logic [63:0]       in_time,
	input  logic [31:0]       in_accel,
	input  wjse_pkg::wjse_cmd_t cmd,
	output wjse_pkg::wjse_sts_t sts,
	output logic [31:0]       jerk_avg,
	output logic [31:0]       snap_avg,
	output logic              zero_flag
);
	import wjse_pkg::*;

	logic [31:0] prev_accel_q;
	logic [63:0] prev_time_q;
	logic [31:0] jerk_ring_q [JerkDepth];
	logic [31:0] snap_ring_q [SnapDepth];
	logic signed [TotalW-1:0] jerk_total_q, snap_total_q;
	logic [JerkIdxW-1:0] jerk_slot_q;
	logic [SnapIdxW-1:0] snap_slot_q;
	logic [31:0] accel_q, new_jerk_q, new_snap_q;
	logic [63:0] time_q, dmag_q;
	logic        dneg_q, zero_q, nneg_q;
	logic [63:0] prod_q;

	logic [JerkIdxW-1:0] prev_slot;
	logic signed [32:0] diff_a, diff_j, diff;
	logic [32:0] mag;
	logic [63:0] dt, div_num, div_quo;
	logic        div_start, div_busy;
	logic [31:0] sat;

	assign prev_slot = (jerk_slot_q == '0) ? JerkIdxW'(JerkDepth - 1) : jerk_slot_q - 1'b1;
	assign dt = in_time - prev_time_q;
	assign diff_a = $signed({accel_q[31], accel_q}) - $signed({prev_accel_q[31], prev_accel_q});
	assign diff_j = $signed({new_jerk_q[31], new_jerk_q})
		- $signed({jerk_ring_q[prev_slot][31], jerk_ring_q[prev_slot]});
	assign diff = cmd.snap_div ? diff_j : diff_a;
	assign mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign div_num = prod_q;
	// product registered; the divider takes it in the following cycle
	logic start_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_d_q <= 1'b0;
		else start_d_q <= cmd.jerk_div | cmd.snap_div;
	end
	always_ff @(posedge clk) begin
		if (cmd.jerk_div | cmd.snap_div) begin
			prod_q <= 64'(mag) * 64'(tps);
			nneg_q <= diff[32];
		end
	end
	assign div_start = start_d_q;

	wjse_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(dmag_q), .busy(div_busy), .quo(div_quo)
	);

	always_comb begin
		if (zero_q) sat = 32'd0;
		else if (nneg_q != dneg_q) sat = (div_quo > 64'h8000_0000) ? 32'h8000_0000
			: 32'(-div_quo);
		else sat = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
	end

	// latched rate result: first pass gives jerk, second gives snap
	logic which_q, div_busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			which_q <= 1'b0;
			div_busy_q <= 1'b0;
		end else begin
			div_busy_q <= div_busy | div_start;
			if (cmd.jerk_div) which_q <= 1'b0;
			else if (cmd.snap_div) which_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			accel_q <= in_accel;
			time_q  <= in_time;
			zero_q  <= (dt == 64'd0);
			dneg_q  <= dt[63];
			dmag_q  <= dt[63] ? 64'(-dt) : dt;
		end
		if (div_busy_q && !div_busy && !div_start) begin
			if (which_q) new_snap_q <= sat;
			else new_jerk_q <= sat;
		end
	end
	assign sts.div_busy = div_busy | div_start | (div_busy_q && !div_busy);

	logic signed [TotalW-1:0] jt_next, st_next;
	assign jt_next = jerk_total_q - TotalW'($signed(jerk_ring_q[jerk_slot_q]))
		+ TotalW'($signed(new_jerk_q));
	assign st_next = snap_total_q - TotalW'($signed(snap_ring_q[snap_slot_q]))
		+ TotalW'($signed(new_snap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_accel_q <= '0;
			prev_time_q <= '0;
			jerk_total_q <= '0;
			snap_total_q <= '0;
			jerk_slot_q <= '0;
			snap_slot_q <= '0;
			zero_flag <= 1'b0;
			for (int i = 0; i < JerkDepth; i++) jerk_ring_q[i] <= '0;
			for (int i = 0; i < SnapDepth; i++) snap_ring_q[i] <= '0;
		end else if (cmd.update) begin
			jerk_ring_q[jerk_slot_q] <= new_jerk_q;
			snap_ring_q[snap_slot_q] <= new_snap_q;
			jerk_total_q <= jt_next;
			snap_total_q <= st_next;
			jerk_slot_q <= (jerk_slot_q == JerkIdxW'(JerkDepth - 1)) ? '0 : jerk_slot_q + 1'b1;
			snap_slot_q <= (snap_slot_q == SnapIdxW'(SnapDepth - 1)) ? '0 : snap_slot_q + 1'b1;
			prev_accel_q <= accel_q;
			prev_time_q <= time_q;
			zero_flag <= zero_q;
		end
	end

	// means: magnitude of each sum times the depth reciprocal, low half of
	// the reciprocal in the first step, high half added in the second
	logic [MagW-1:0]          amag_q [2];
	logic                     an_q [2];
	logic [AvgProdW-1:0]      acc_q [2];
	logic [1:0]               acnt_q;
	logic [MagW+RecipLoW-1:0] plo [2];
	logic [MagW+RecipHiW-1:0] phi [2];
	logic [31:0]              jerk_quo, snap_quo;

	always_comb begin
		plo[0] = amag_q[0] * JerkRecip[RecipLoW-1:0];
		plo[1] = amag_q[1] * SnapRecip[RecipLoW-1:0];
		phi[0] = amag_q[0] * JerkRecip[TotalW-1:RecipLoW];
		phi[1] = amag_q[1] * SnapRecip[TotalW-1:RecipLoW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acnt_q <= '0;
		else if (cmd.avg_start) acnt_q <= 2'd2;
		else if (acnt_q != '0) acnt_q <= acnt_q - 2'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.avg_start) begin
			an_q[0] <= jerk_total_q[TotalW-1];
			an_q[1] <= snap_total_q[TotalW-1];
			amag_q[0] <= jerk_total_q[TotalW-1] ? MagW'(-jerk_total_q) : MagW'(jerk_total_q);
			amag_q[1] <= snap_total_q[TotalW-1] ? MagW'(-snap_total_q) : MagW'(snap_total_q);
		end else if (acnt_q == 2'd2) begin
			for (int k = 0; k < 2; k++) acc_q[k] <= AvgProdW'(plo[k]);
		end else if (acnt_q == 2'd1) begin
			for (int k = 0; k < 2; k++) acc_q[k] <= acc_q[k] + {phi[k], {RecipLoW{1'b0}}};
		end
	end
	assign sts.avg_busy = (acnt_q != '0);
	assign jerk_quo = acc_q[0][JerkShift +: 32];
	assign snap_quo = acc_q[1][SnapShift +: 32];
	assign jerk_avg = an_q[0] ? 32'(-jerk_quo) : jerk_quo;
	assign snap_avg = an_q[1] ? 32'(-snap_quo) : snap_quo;
endmodule

// ===== hw/rtl/wjse_ctrl.sv =====
// ----------------------------------------------------------------------------
// wjse_ctrl
// Sequencer: load, jerk division, snap division, update, means, output.
// ----------------------------------------------------------------------------
module wjse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output wjse_pkg::wjse_cmd_t cmd,
	input  wjse_pkg::wjse_sts_t sts
);
	import wjse_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_JDIV  = 8'b0000_0010,
		ST_JWAIT = 8'b0000_0100,
		ST_SDIV  = 8'b0000_1000,
		ST_SWAIT = 8'b0001_0000,
		ST_UPD   = 8'b0010_0000,
		ST_AVG   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT) && !sts.avg_busy;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				state_d = ST_JDIV;
			end
			ST_JDIV: begin
				cmd.jerk_div = 1'b1;
				state_d = ST_JWAIT;
			end
			ST_JWAIT: if (!sts.div_busy) state_d = ST_SDIV;
			ST_SDIV: begin
				cmd.snap_div = 1'b1;
				state_d = ST_SWAIT;
			end
			ST_SWAIT: if (!sts.div_busy) state_d = ST_UPD;
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = ST_AVG;
			end
			ST_AVG: begin
				cmd.avg_start = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: if (out_ready && !sts.avg_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed jerk and snap estimator. A driver pulls
// sample items from a queue filled by the stimulus process. A behavioral
// predictor computes the expected window means, and a monitor compares them
// field by field against the results seen on the output stream.
// ----------------------------------------------------------------------------
module tb_top;
	import wjse_pkg::*;

	typedef struct packed {
		logic [31:0] accel;
		logic [63:0] stamp;
	} sample_t;

	typedef struct packed {
		logic        zero_step;
		logic [31:0] snap_avg;
		logic [31:0] jerk_avg;
	} means_t;

	localparam int StallLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [29:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;

	windowed_jerk_snap_estimator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// predictor state
	logic [29:0]        tps;
	logic signed [31:0] prev_accel;
	logic [63:0]        prev_stamp;
	logic signed [31:0] jerk_ring [JerkDepth];
	logic signed [31:0] snap_ring [SnapDepth];
	logic signed [63:0] jerk_sum;
	logic signed [63:0] snap_sum;
	int                 jerk_ptr;
	int                 snap_ptr;

	sample_t pending_samples[$];
	means_t  expected_means[$];
	int      mismatch_count;
	int      idle_cycles;
	bit      stim_done;
	bit      send_hold;
	logic [63:0] prev_stamp_guess;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(40, 200);
	endfunction

	// (b - a) * tps / dt with truncation toward zero, clamped to 32 bits
	function automatic logic signed [31:0] rate_of(logic signed [31:0] a,
			logic signed [31:0] b, logic [63:0] dt);
		logic signed [33:0] diff;
		logic [63:0] mag, num, dmag, q;
		logic neg, dneg;
		diff = 34'(b) - 34'(a);
		neg = diff[33];
		mag = neg ? 64'(-diff) : 64'(diff);
		num = mag * 64'(tps);
		dneg = dt[63];
		dmag = dneg ? (64'd0 - dt) : dt;
		q = num / dmag;
		if (neg != dneg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return 32'(q);
	endfunction

	function automatic means_t predict_means(sample_t s);
		means_t m;
		logic [63:0] dt;
		logic signed [31:0] nj, ns, last_jerk;
		logic signed [63:0] qj, qs;
		dt = s.stamp - prev_stamp;
		last_jerk = jerk_ring[(jerk_ptr + JerkDepth - 1) % JerkDepth];
		nj = 0;
		ns = 0;
		if (dt != 0) begin
			nj = rate_of(prev_accel, s.accel, dt);
			ns = rate_of(last_jerk, nj, dt);
		end
		jerk_sum = jerk_sum - jerk_ring[jerk_ptr] + nj;
		jerk_ring[jerk_ptr] = nj;
		jerk_ptr = (jerk_ptr + 1) % JerkDepth;
		snap_sum = snap_sum - snap_ring[snap_ptr] + ns;
		snap_ring[snap_ptr] = ns;
		snap_ptr = (snap_ptr + 1) % SnapDepth;
		prev_accel = s.accel;
		prev_stamp = s.stamp;
		qj = jerk_sum / JerkDepth;
		qs = snap_sum / SnapDepth;
		m.jerk_avg = qj[31:0];
		m.snap_avg = qs[31:0];
		m.zero_step = (dt == 0);
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatch_count++;
	endtask

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
			prev_accel = 0;
			prev_stamp = 0;
			jerk_sum = 0;
			snap_sum = 0;
			jerk_ptr = 0;
			snap_ptr = 0;
			for (int i = 0; i < JerkDepth; i++) jerk_ring[i] = 0;
			for (int i = 0; i < SnapDepth; i++) snap_ring[i] = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_means.push_back(predict_means(sample_t'(s_axis_tdata)));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0 && !send_hold) begin
					s_axis_tdata <= pending_samples.pop_front();
					s_axis_tvalid <= 1'b1;
					send_gap <= gap_len();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		means_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_means.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
				end else begin
					want = expected_means.pop_front();
					if (m_axis_tdata[31:0] !== want.jerk_avg)
						report_mismatch("jerk_average", m_axis_tdata[31:0], want.jerk_avg);
					if (m_axis_tdata[63:32] !== want.snap_avg)
						report_mismatch("snap_average", m_axis_tdata[63:32], want.snap_avg);
					if (m_axis_tuser !== want.zero_step)
						report_mismatch("zero_step_flag", 32'(m_axis_tuser),
							32'(want.zero_step));
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (m_axis_tvalid && m_axis_tready) recv_gap <= gap_len();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (pending_samples.size() == 0 && expected_means.size() == 0
				&& !s_axis_tvalid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() > 0 || s_axis_tvalid || expected_means.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_tps(logic [29:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		tps = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_sample(logic [63:0] t, logic [31:0] a);
		sample_t s;
		s.stamp = t;
		s.accel = a;
		pending_samples.push_back(s);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly steady forward motion with random accel, some odd steps
	task automatic random_phase(int n);
		logic [63:0] t;
		logic [31:0] a;
		int r;
		t = prev_stamp_guess;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) t = t + $urandom_range(1, 2000);
			else if (r < 70) t = t;
			else if (r < 78) t = t - $urandom_range(1, 2000);
			else if (r < 88) t = t + {$urandom_range(0, 15), $urandom()};
			else t = rand64();
			r = $urandom_range(0, 99);
			if (r < 50) a = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			else if (r < 60) a = (r & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			else a = $urandom();
			add_sample(t, a);
		end
		prev_stamp_guess = t;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_hold = 1'b0;
		tps = TpsReset;
		prev_stamp_guess = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first sample at time zero, extremes, negative and minimal steps
		add_sample(64'd0, 32'h0001_0000);
		add_sample(64'd1, 32'h7FFF_FFFF);
		add_sample(64'd2, 32'h8000_0000);
		add_sample(64'd2, 32'h0000_0000);
		add_sample(64'd1, 32'h7FFF_FFFF);
		add_sample(64'h8000_0000_0000_0001, 32'h8000_0000);
		add_sample(64'h0000_0000_0000_0001, 32'h1234_5678);
		add_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		add_sample(64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
		add_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
		for (int i = 0; i < 8; i++) add_sample(64'd1000 + i * 1000, 32'(i * 32'h0003_0000));
		prev_stamp_guess = 64'd8000;
		wait_drained();

		// register extremes: largest, smallest, zero
		write_tps(30'h3FFF_FFFF);
		random_phase(60);
		// hold the sender mid-phase until every result is back
		while (pending_samples.size() > 30) @(posedge clk);
		send_hold = 1'b1;
		while (s_axis_tvalid || expected_means.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		send_hold = 1'b0;
		wait_drained();
		write_tps(30'd1);
		random_phase(60);
		wait_drained();
		write_tps(30'd0);
		random_phase(40);
		wait_drained();
		write_tps(30'd1000000000);
		random_phase(80);
		wait_drained();
		write_tps(30'($urandom()));
		random_phase(80);
		wait_drained();
		write_tps(TpsReset);
		random_phase(80);
		wait_drained();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
